// ===== rtl/prime_table_trial_division_assert.svh =====
// assertion macros for the prime table block
`ifndef PRIME_TABLE_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_TABLE_TRIAL_DIVISION_ASSERT_SVH

// same-cycle implication
`define PTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
`default_nettype none
package ptd_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int TBL_AW       = $clog2(TABLE_DEPTH);
    localparam int POS_W        = $clog2(TABLE_DEPTH + 1);
    localparam int DVD_W        = 32;
    localparam int DIV_W        = 17;
    localparam int CNT_W        = $clog2(DVD_W);

    localparam logic [7:0]       END_MARK    = 8'hFF;
    localparam logic [17:0]      DIVISOR_MAX = 18'd131071;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_BELOW_TWO = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NONE      = 2'd2
    } t_status;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_index;
        logic [7:0]  entry_value;
        logic [31:0] dividend;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [16:0] divisor;
        logic [31:0] quotient;
    } t_result;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
        logic [DIV_W-1:0]  remainder;
    } t_div_res;

endpackage
`default_nettype wire

// ===== rtl/ptd_div.sv =====
`default_nettype none
module ptd_div
    import ptd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output t_div_res              o_res
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_div, n_div;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_sub;
    logic             w_ge;

    // one restoring step per cycle
    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_sub   = w_shift - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[DIV_W-1:0] : w_shift[DIV_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule
`default_nettype wire

// ===== rtl/ptd_table.sv =====
`default_nettype none
module ptd_table
    import ptd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [TBL_AW-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [TBL_AW-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0]             r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [7:0]             r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : END_MARK;
    end

    // unwritten entries read as end markers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/prime_table_trial_division.sv =====
// write item: busy stays low, no result
// query below two: result strobe in the cycle after the item is accepted
// query: each nonzero table prime is tried in turn (test, divider, step, gap read), a
//   zero prime skips the divider; the walk covers at most a full 256-entry table;
//   one result per query, never stalled; synchronous active-low reset sets first_prime
//   to 2, all entries end markers
`default_nettype none
module prime_table_trial_division
    import ptd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_WAIT,
        S_STEP,
        S_GAP
    } t_state;

    t_state           r_state, n_state;
    logic [15:0]      r_first;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DIV_W-1:0] r_cand, n_cand;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_done, n_done;
    t_result          r_res, n_res;

    logic             w_div_start;
    t_div_res         w_div;
    logic             w_tbl_we;
    logic [7:0]       w_gap;
    logic [17:0]      w_sum;

    ptd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_cand),
        .o_res      (w_div)
    );

    ptd_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tbl_we),
        .i_waddr (TBL_AW'(i_item.entry_index)),
        .i_wdata (i_item.entry_value),
        .i_raddr (r_pos[TBL_AW-1:0]),
        .o_rdata (w_gap)
    );

    always_comb begin
        n_state     = r_state;
        n_dvd       = r_dvd;
        n_cand      = r_cand;
        n_pos       = r_pos;
        n_done      = 1'b0;
        n_res       = r_res;
        w_div_start = 1'b0;
        w_tbl_we    = 1'b0;
        w_sum       = 18'(r_cand) + 18'(w_gap);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.operation == OP_WRITE) begin
                        w_tbl_we = (32'(i_item.entry_index) < TABLE_DEPTH);
                    end else if (i_item.dividend < 32'd2) begin
                        n_done = 1'b1;
                        n_res  = '{status: ST_BELOW_TWO, divisor: '0, quotient: '0};
                    end else begin
                        n_dvd   = i_item.dividend;
                        n_cand  = DIV_W'(r_first);
                        n_pos   = '0;
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (r_cand != '0) begin
                    w_div_start = 1'b1;
                    n_state     = S_WAIT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_WAIT: begin
                if (w_div.done) begin
                    if (w_div.remainder == '0) begin
                        n_done  = 1'b1;
                        n_res   = '{status: ST_FOUND, divisor: r_cand,
                                    quotient: w_div.quotient};
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (32'(r_pos) >= TABLE_DEPTH) begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_NONE, divisor: '0, quotient: '0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                if (w_gap == END_MARK || w_sum > DIVISOR_MAX) begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_NONE, divisor: '0, quotient: '0};
                    n_state = S_IDLE;
                end else begin
                    n_cand  = w_sum[DIV_W-1:0];
                    n_pos   = r_pos + 1'b1;
                    n_state = S_TEST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_first <= 16'd2;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_first <= i_cfg_wdata;
            end
        end
        r_dvd  <= n_dvd;
        r_cand <= n_cand;
        r_pos  <= n_pos;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`include "prime_table_trial_division_assert.svh"

    `PTD_ASSERT_NOW(a_done_has_cause, o_done, $past(busy) || $past(start),
        "result without an item")
    `PTD_ASSERT_NOW(a_found_nonzero, o_done && o_result.status == ST_FOUND,
        o_result.divisor != '0, "found with zero divisor")
    `PTD_ASSERT_NOW(a_miss_zero, o_done && o_result.status != ST_FOUND,
        o_result.divisor == '0 && o_result.quotient == '0, "miss with nonzero payload")
    `PTD_ASSERT_NEXT(a_query_busy,
        start && !busy && i_item.operation == OP_QUERY && i_item.dividend >= 32'd2,
        busy && !o_done, "query did not start the walk")

endmodule
`default_nettype wire
